/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
// Depends on nothing; expects i_clk and i_rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, masked while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication that holds in the same cycle
`define ASSERT_IMPL(label, cond, prop, msg) \
    `ASSERT_CLK(label, (cond) |-> (prop), msg)

`endif

/* hw/rtl/ntt_pkg.sv */
// Shared types and constants of the port translation table.
// No dependencies.
package ntt_pkg;

    localparam int ENTRIES     = 64;
    localparam int MAX_RETRIES = 16;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int TRY_W       = $clog2(MAX_RETRIES + 1);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_W       = 16;

    localparam logic [15:0] PORT_LOW     = 16'd1024;
    localparam logic [15:0] PORT_SPAN    = 16'd64511;
    localparam logic [15:0] LFSR_TAPS    = 16'hB400;
    localparam logic [15:0] TIMEOUT_RST  = 16'd60;
    localparam logic [15:0] SEED_RST     = 16'd1;

    localparam logic [1:0] CMD_OUT  = 2'd0;
    localparam logic [1:0] CMD_IN   = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_NEW  = 2'd1;
    localparam logic [1:0] ST_DROP = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SEED    = CFG_IDX_W'(1);

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] priv_ip;
        logic [15:0] priv_port;
        logic [47:0] priv_mac;
        logic [31:0] remote_ip;
        logic [15:0] ext_port;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] mapped_port;
        logic [31:0] host_ip;
        logic [15:0] host_port;
        logic [47:0] host_mac;
        logic [31:0] peer_ip;
    } t_res;

    typedef struct packed {
        logic [31:0] host_ip;
        logic [15:0] host_port;
        logic [47:0] host_mac;
        logic [31:0] peer_ip;
        logic [15:0] pub_port;
        logic [31:0] touch;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [15:0] timeout;
        logic        seed_load;
        logic [15:0] seed;
    } t_cfg;

    typedef struct packed {
        logic valid;
        t_in  item;
    } t_qhead;

    function automatic logic [15:0] lfsr_step(input logic [15:0] l);
        logic [15:0] n;
        n = l >> 1;
        if (l[0]) n = n ^ LFSR_TAPS;
        return n;
    endfunction

endpackage

/* hw/rtl/ntt_ram.sv */
// Generic single write port RAM with registered read.
// No dependencies.
module ntt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/ntt_front.sv */
// Front end: accepts command beats, drops unused codes, queues the rest.
// Depends on ntt_pkg.
module ntt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ntt_pkg::t_in   i_item,
    output logic           o_busy,
    input  logic           i_pop,
    output ntt_pkg::t_qhead o_head
);
    ntt_pkg::t_in r_q [ntt_pkg::QDEPTH];
    logic [ntt_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [ntt_pkg::QCNT_W-1:0] r_cnt;
    logic push, pop;

    assign o_busy = (r_cnt == ntt_pkg::QCNT_W'(ntt_pkg::QDEPTH));
    assign push = i_start && !o_busy && (i_item.cmd != ntt_pkg::CMD_NONE);
    assign pop  = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == ntt_pkg::QPTR_W'(ntt_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == ntt_pkg::QPTR_W'(ntt_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (push && !pop) r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_item;
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rp];
endmodule

/* hw/rtl/ntt_back.sv */
// Back end: scans the table one entry at a time, allocates ports, ages entries.
// Depends on ntt_pkg and ntt_ram.
module ntt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ntt_pkg::t_cfg   i_cfg,
    input  ntt_pkg::t_qhead i_head,
    output logic            o_pop,
    output logic            o_res_valid,
    output ntt_pkg::t_res   o_res
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_CHK  = 4'b0100,
        S_DRAW = 4'b1000
    } t_state;

    t_state r_state, n_state;
    ntt_pkg::t_in r_item, n_item;
    logic r_pmode, n_pmode;
    logic [ntt_pkg::IDX_W-1:0] r_idx, n_idx, r_slot, n_slot;
    logic r_slot_ok, n_slot_ok;
    logic [15:0] r_port, n_port, r_lfsr, n_lfsr;
    logic [ntt_pkg::TRY_W-1:0] r_tries, n_tries;
    logic [31:0] r_now, n_now;
    logic [ntt_pkg::ENTRIES-1:0] r_valid, n_valid;
    logic r_res_valid, n_res_valid;
    ntt_pkg::t_res r_res, n_res;

    logic we;
    ntt_pkg::t_entry wdata, d;
    logic [ntt_pkg::IDX_W-1:0] waddr;
    logic [ntt_pkg::ENTRY_W-1:0] rdata;
    logic live, last;
    logic [31:0] age;
    logic [15:0] lfsr_n, port_mod;

    ntt_ram #(.WIDTH(ntt_pkg::ENTRY_W), .DEPTH(ntt_pkg::ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(r_idx),
        .o_rdata(rdata)
    );

    assign d      = ntt_pkg::t_entry'(rdata);
    assign age    = r_now - d.touch;
    assign live   = r_valid[r_idx] && (age < {16'd0, i_cfg.timeout});
    assign last   = (r_idx == ntt_pkg::IDX_W'(ntt_pkg::ENTRIES - 1));
    assign lfsr_n = ntt_pkg::lfsr_step(r_lfsr);
    // lfsr value is below twice the span, so one subtract reduces it
    assign port_mod = ((lfsr_n >= ntt_pkg::PORT_SPAN) ? lfsr_n - ntt_pkg::PORT_SPAN : lfsr_n)
                      + ntt_pkg::PORT_LOW;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_pmode     = r_pmode;
        n_idx       = r_idx;
        n_slot      = r_slot;
        n_slot_ok   = r_slot_ok;
        n_port      = r_port;
        n_lfsr      = r_lfsr;
        n_tries     = r_tries;
        n_now       = r_now;
        n_valid     = r_valid;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_pop       = 1'b0;
        we          = 1'b0;
        waddr       = r_idx;
        wdata       = d;

        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop  = 1'b1;
                    n_item = i_head.item;
                    if (i_head.item.cmd == ntt_pkg::CMD_TICK) begin
                        n_now = r_now + 32'd1;
                    end else begin
                        n_idx     = '0;
                        n_pmode   = 1'b0;
                        n_slot_ok = 1'b0;
                        n_tries   = '0;
                        n_state   = S_RD;
                    end
                end
            end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                n_state = S_RD;
                n_idx   = r_idx + 1'b1;
                if (!r_pmode) begin
                    if (live && ((r_item.cmd == ntt_pkg::CMD_IN)
                            ? (d.peer_ip == r_item.remote_ip && d.pub_port == r_item.ext_port)
                            : (d.host_ip == r_item.priv_ip
                               && d.host_port == r_item.priv_port
                               && d.peer_ip == r_item.remote_ip))) begin
                        we          = 1'b1;
                        wdata.touch = r_now;
                        n_res_valid = 1'b1;
                        n_res       = '{ntt_pkg::ST_HIT, d.pub_port, d.host_ip, d.host_port,
                                        d.host_mac, d.peer_ip};
                        n_state     = S_IDLE;
                    end else begin
                        if (!live && !r_slot_ok) begin
                            n_slot    = r_idx;
                            n_slot_ok = 1'b1;
                        end
                        if (last) begin
                            if (r_item.cmd == ntt_pkg::CMD_IN) begin
                                n_res_valid = 1'b1;
                                n_res       = '{ntt_pkg::ST_DROP, 16'd0, 32'd0, 16'd0, 48'd0, 32'd0};
                                n_state     = S_IDLE;
                            end else if (!r_slot_ok && live) begin
                                n_res_valid = 1'b1;
                                n_res       = '{ntt_pkg::ST_FULL, 16'd0, 32'd0, 16'd0, 48'd0, 32'd0};
                                n_state     = S_IDLE;
                            end else begin
                                n_state = S_DRAW;
                            end
                        end
                    end
                end else begin
                    if (r_idx != r_slot && r_valid[r_idx] && d.pub_port == r_port) begin
                        // port collision: redraw or give up
                        if (r_tries == ntt_pkg::TRY_W'(ntt_pkg::MAX_RETRIES)) begin
                            n_res_valid = 1'b1;
                            n_res       = '{ntt_pkg::ST_FULL, 16'd0, 32'd0, 16'd0, 48'd0, 32'd0};
                            n_state     = S_IDLE;
                        end else begin
                            n_state = S_DRAW;
                        end
                    end else if (last) begin
                        we       = 1'b1;
                        waddr    = r_slot;
                        wdata    = '{r_item.priv_ip, r_item.priv_port, r_item.priv_mac,
                                     r_item.remote_ip, r_port, r_now};
                        n_valid[r_slot] = 1'b1;
                        n_res_valid = 1'b1;
                        n_res    = '{ntt_pkg::ST_NEW, r_port, r_item.priv_ip,
                                     r_item.priv_port, r_item.priv_mac, r_item.remote_ip};
                        n_state  = S_IDLE;
                    end
                end
            end
            S_DRAW: begin
                n_lfsr  = lfsr_n;
                n_port  = port_mod;
                n_tries = r_tries + 1'b1;
                n_pmode = 1'b1;
                n_idx   = '0;
                n_state = S_RD;
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg.seed_load) n_lfsr = (i_cfg.seed == 16'd0) ? 16'd1 : i_cfg.seed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_valid     <= '0;
            r_lfsr      <= ntt_pkg::SEED_RST;
            r_res_valid <= 1'b0;
            r_pmode     <= 1'b0;
            r_slot_ok   <= 1'b0;
            r_tries     <= '0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_valid     <= n_valid;
            r_lfsr      <= n_lfsr;
            r_res_valid <= n_res_valid;
            r_pmode     <= n_pmode;
            r_slot_ok   <= n_slot_ok;
            r_tries     <= n_tries;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_slot <= n_slot;
        r_port <= n_port;
        r_res  <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
endmodule

/* hw/rtl/nat_translation_table.sv */
// Top level of the port translation table: config registers, front queue, back engine.
// Depends on ntt_pkg, ntt_front, ntt_back, assert_macros.svh.
//
// Commands are taken while busy is low; a two-deep queue lets new beats in while
// the engine works. A tick is handled in the engine's idle state. A lookup walks
// the entries in order through the table RAM's single read port, with a read state
// and a check state per entry, and stops at the first hit; an outbound miss then
// draws a port and walks the table again for collisions, up to MAX_RETRIES draws.
// The result appears on o_res for one cycle with o_res_valid and cannot be held
// off. No clearing pass is needed after reset: entry valid bits reset in flops.
`include "assert_macros.svh"
module nat_translation_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  ntt_pkg::t_in                    i_item,
    output logic                            busy,
    output logic                            o_res_valid,
    output ntt_pkg::t_res                   o_res,
    input  logic                            i_cfg_we,
    input  logic [ntt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ntt_pkg::CFG_W-1:0]       i_cfg_data
);
    logic [15:0] r_timeout;
    ntt_pkg::t_cfg cfg;
    ntt_pkg::t_qhead head;
    logic pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= ntt_pkg::TIMEOUT_RST;
        end else if (i_cfg_we && i_cfg_idx == ntt_pkg::CFG_TIMEOUT) begin
            r_timeout <= i_cfg_data;
        end
    end

    assign cfg.timeout   = r_timeout;
    assign cfg.seed_load = i_cfg_we && (i_cfg_idx == ntt_pkg::CFG_SEED);
    assign cfg.seed      = i_cfg_data;

    ntt_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_item (i_item),
        .o_busy (busy),
        .i_pop  (pop),
        .o_head (head)
    );

    ntt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_head     (head),
        .o_pop      (pop),
        .o_res_valid(o_res_valid),
        .o_res      (o_res)
    );

    `ASSERT_IMPL(a_new_port_range, o_res_valid && o_res.status == ntt_pkg::ST_NEW,
        o_res.mapped_port >= ntt_pkg::PORT_LOW && o_res.mapped_port != 16'hFFFF,
        "new mapping port out of range")
    `ASSERT_IMPL(a_empty_result, o_res_valid && (o_res.status == ntt_pkg::ST_DROP
        || o_res.status == ntt_pkg::ST_FULL),
        o_res.mapped_port == 16'd0 && o_res.host_ip == 32'd0 && o_res.peer_ip == 32'd0,
        "drop or full result carries data")
    `ASSERT_CLK(a_result_spacing, o_res_valid |=> !o_res_valid,
        "results on consecutive cycles")
endmodule
